@@ hdl/edf_pkg.sv @@
// Package for the EDF ready queue: transaction types, codes and sizes.
// No dependencies.
`timescale 1ns / 1ps
package edf_pkg;

  localparam int MAX_TASKS = 32;
  localparam int IDX_W     = $clog2(MAX_TASKS);
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);

  typedef enum logic [1:0] {
    ACT_CREATE   = 2'd0,
    ACT_COMPLETE = 2'd1,
    ACT_EXPIRE   = 2'd2,
    ACT_FLUSH    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] task_id;
    logic [23:0] relative_deadline;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    logic        head_valid;
    logic [15:0] head_task_id;
    logic [31:0] head_deadline;
    logic [5:0]  active_count;
    logic [15:0] overdue_count;
    logic [15:0] last_overdue_id;
    logic [1:0]  status;
  } result_t;

  typedef struct packed {
    logic [15:0] id;
    logic [31:0] deadline;
  } entry_t;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_FULL, OP_CRD, OP_CINS, OP_CSHIFT,
    OP_RRD, OP_RCMP, OP_RFIN, OP_FLUSH, OP_HRD, OP_RESP
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_C_RD, S_C_CMP, S_R_RD, S_R_CMP, S_H_RD, S_H_WAIT
  } state_e;

  // Status from datapath to controller
  typedef struct packed {
    logic [1:0] action;
    logic       full;
    logic       cur_zero;
    logic       cur_end;
    logic       dl_le;
  } dp_stat_t;

endpackage

@@ hdl/edf_ctrl.sv @@
// Controller of the EDF ready queue: sequences insert, remove, flush and head read.
// Depends on edf_pkg.
`timescale 1ns / 1ps
module edf_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  edf_pkg::dp_stat_t stat_i,
  output edf_pkg::op_e     op_o
);
  import edf_pkg::*;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  // Next state and operation
  always_comb begin
    state_d = state_q;
    op_o    = OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          op_o    = OP_LOAD;
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        unique case (stat_i.action)
          ACT_CREATE: begin
            if (stat_i.full) begin
              op_o    = OP_FULL;
              state_d = S_H_RD;
            end else begin
              state_d = S_C_RD;
            end
          end
          ACT_COMPLETE, ACT_EXPIRE: state_d = S_R_RD;
          default: begin
            op_o    = OP_FLUSH;
            state_d = S_H_RD;
          end
        endcase
      end
      S_C_RD: begin
        if (stat_i.cur_zero) begin
          op_o    = OP_CINS;
          state_d = S_H_RD;
        end else begin
          op_o    = OP_CRD;
          state_d = S_C_CMP;
        end
      end
      S_C_CMP: begin
        if (stat_i.dl_le) begin
          op_o    = OP_CINS;
          state_d = S_H_RD;
        end else begin
          op_o    = OP_CSHIFT;
          state_d = S_C_RD;
        end
      end
      S_R_RD: begin
        if (stat_i.cur_end) begin
          op_o    = OP_RFIN;
          state_d = S_H_RD;
        end else begin
          op_o    = OP_RRD;
          state_d = S_R_CMP;
        end
      end
      S_R_CMP: begin
        op_o    = OP_RCMP;
        state_d = S_R_RD;
      end
      S_H_RD: begin
        op_o    = OP_HRD;
        state_d = S_H_WAIT;
      end
      S_H_WAIT: begin
        op_o    = OP_RESP;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy = (state_q != S_IDLE);

endmodule

@@ hdl/edf_dpath.sv @@
// Datapath of the EDF ready queue: sorted entry memory, counters, result register.
// Depends on edf_pkg.
`timescale 1ns / 1ps
module edf_dpath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  edf_pkg::op_e      op_i,
  input  edf_pkg::item_t    item_i,
  output edf_pkg::dp_stat_t stat_o,
  output logic              done_o,
  output edf_pkg::result_t  result_o
);
  import edf_pkg::*;

  entry_t           mem [MAX_TASKS];
  entry_t           rdata_q;
  item_t            in_q;
  logic [31:0]      abs_q;
  logic [CNT_W-1:0] cur_q, used_q;
  logic             found_q;
  logic [15:0]      ovd_q, last_q;
  status_e          status_q;
  logic             done_q;
  result_t          res_q;
  logic [32:0]      sum;
  logic [IDX_W-1:0] cur_idx, prev_idx;
  logic             id_match;

  assign sum      = {1'b0, item_i.now_ms} + {9'b0, item_i.relative_deadline};
  assign cur_idx  = cur_q[IDX_W-1:0];
  assign prev_idx = IDX_W'(cur_q - CNT_W'(1));
  assign id_match = (rdata_q.id == in_q.task_id);

  assign stat_o.action   = in_q.action;
  assign stat_o.full     = (used_q == CNT_W'(MAX_TASKS));
  assign stat_o.cur_zero = (cur_q == '0);
  assign stat_o.cur_end  = (cur_q == used_q);
  assign stat_o.dl_le    = (rdata_q.deadline <= abs_q);

  // Entry memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    unique case (op_i)
      OP_CINS:   mem[cur_idx] <= '{id: in_q.task_id, deadline: abs_q};
      OP_CSHIFT: mem[cur_idx] <= rdata_q;
      OP_RCMP:   if (found_q) mem[prev_idx] <= rdata_q;
      default: ;
    endcase
    unique case (op_i)
      OP_CRD:  rdata_q <= mem[prev_idx];
      OP_RRD:  rdata_q <= mem[cur_idx];
      OP_HRD:  rdata_q <= mem[0];
      default: ;
    endcase
  end

  // Transaction payload, absolute deadline and result register
  always_ff @(posedge clk_i) begin
    if (op_i == OP_LOAD) begin
      in_q  <= item_i;
      abs_q <= sum[32] ? '1 : sum[31:0];
    end
    if (op_i == OP_RESP) begin
      res_q.head_valid      <= (used_q != '0);
      res_q.head_task_id    <= (used_q != '0) ? rdata_q.id : '0;
      res_q.head_deadline   <= (used_q != '0) ? rdata_q.deadline : '0;
      res_q.active_count    <= 6'(used_q);
      res_q.overdue_count   <= ovd_q;
      res_q.last_overdue_id <= last_q;
      res_q.status          <= status_q;
    end
  end

  // Control state: counts, cursor, status and strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q   <= '0;
      ovd_q    <= '0;
      last_q   <= '0;
      cur_q    <= '0;
      found_q  <= 1'b0;
      status_q <= ST_DONE;
      done_q   <= 1'b0;
    end else begin
      done_q <= (op_i == OP_RESP);
      unique case (op_i)
        OP_LOAD: begin
          cur_q    <= (item_i.action == ACT_CREATE) ? used_q : '0;
          found_q  <= 1'b0;
          status_q <= ST_DONE;
        end
        OP_FULL:   status_q <= ST_FULL;
        OP_CINS:   used_q <= used_q + CNT_W'(1);
        OP_CSHIFT: cur_q <= cur_q - CNT_W'(1);
        OP_RCMP: begin
          if (!found_q && id_match) found_q <= 1'b1;
          cur_q <= cur_q + CNT_W'(1);
        end
        OP_RFIN: begin
          if (found_q) begin
            used_q <= used_q - CNT_W'(1);
            if (in_q.action == ACT_EXPIRE) begin
              if (ovd_q != '1) ovd_q <= ovd_q + 16'd1;
              last_q <= in_q.task_id;
            end
          end else begin
            status_q <= ST_NOT_FOUND;
          end
        end
        OP_FLUSH: begin
          used_q <= '0;
          ovd_q  <= '0;
          last_q <= '0;
        end
        default: ;
      endcase
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  a_used_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CNT_W'(MAX_TASKS)) else $error("active count beyond store size");
  a_head_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (res_q.head_valid == (res_q.active_count != '0)))
    else $error("head valid disagrees with count");
  a_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("result strobe longer than one cycle");
  a_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_q <= CNT_W'(MAX_TASKS)) else $error("cursor past end of store");

endmodule

@@ hdl/edf_ready_queue.sv @@
// Top level of the EDF ready queue: controller plus datapath.
// Each transaction (create, complete, expire, flush) starts when start is high and
// busy low, and yields exactly one result on result_o marked by a one-cycle done_o;
// the receiver cannot stall it. A create walks the queue from its tail, shifting
// up each queued task with a later deadline; a complete or expire walks the whole
// queue; a flush or refused create goes straight to the head read. The next
// transaction can be accepted at the edge that takes the result. The time is set
// by the walk over the entry memory, one read and one compare or shift per entry.
// Depends on edf_pkg, edf_ctrl, edf_dpath.
`timescale 1ns / 1ps
module edf_ready_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  edf_pkg::item_t   item_i,
  output logic             done_o,
  output edf_pkg::result_t result_o
);
  import edf_pkg::*;

  op_e      op;
  dp_stat_t stat;

  edf_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .op_o   (op)
  );

  edf_dpath u_dpath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .op_i     (op),
    .item_i   (item_i),
    .stat_o   (stat),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule

@@ test/edf_ready_queue_tb.sv @@
// Testbench for the EDF ready queue: drives create, complete, expire and flush
// transactions and checks every result against a behavioural scheduler model.
// Depends on edf_pkg and edf_ready_queue.
`timescale 1ns / 1ps
module edf_ready_queue_tb;
  import edf_pkg::*;

  logic    clk_i;
  logic    rst_ni;
  logic    start;
  logic    busy;
  item_t   item_i;
  logic    done_o;
  result_t result_o;

  edf_ready_queue u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .item_i(item_i), .done_o(done_o), .result_o(result_o)
  );

  // Scheduler model state
  logic [15:0] sched_ids[MAX_TASKS];
  logic [31:0] sched_dls[MAX_TASKS];
  int          sched_used = 0;
  logic [15:0] sched_overdue = '0;
  logic [15:0] sched_last_id = '0;

  item_t   pending_items[$];
  result_t expected_results[$];
  int      errors = 0;
  int      gap_left;

  // Apply one event to the model and return the result it yields
  function automatic result_t schedule_event(item_t it);
    result_t r;
    logic [32:0] sum;
    logic [31:0] abs_dl;
    int pos;
    r = '0;
    r.status = ST_DONE;
    if (it.action == ACT_CREATE) begin
      if (sched_used >= MAX_TASKS) begin
        r.status = ST_FULL;
      end else begin
        sum = {1'b0, it.now_ms} + {9'd0, it.relative_deadline};
        abs_dl = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        pos = 0;
        while (pos < sched_used && sched_dls[pos] <= abs_dl) pos++;
        for (int i = sched_used; i > pos; i--) begin
          sched_ids[i] = sched_ids[i-1];
          sched_dls[i] = sched_dls[i-1];
        end
        sched_ids[pos] = it.task_id;
        sched_dls[pos] = abs_dl;
        sched_used++;
      end
    end else if (it.action == ACT_COMPLETE || it.action == ACT_EXPIRE) begin
      pos = -1;
      for (int i = 0; i < sched_used; i++)
        if (pos < 0 && sched_ids[i] == it.task_id) pos = i;
      if (pos < 0) begin
        r.status = ST_NOT_FOUND;
      end else begin
        for (int i = pos; i + 1 < sched_used; i++) begin
          sched_ids[i] = sched_ids[i+1];
          sched_dls[i] = sched_dls[i+1];
        end
        sched_used--;
        if (it.action == ACT_EXPIRE) begin
          if (sched_overdue != 16'hFFFF) sched_overdue++;
          sched_last_id = it.task_id;
        end
      end
    end else begin
      sched_used = 0;
      sched_overdue = '0;
      sched_last_id = '0;
    end
    if (sched_used > 0) begin
      r.head_valid = 1'b1;
      r.head_task_id = sched_ids[0];
      r.head_deadline = sched_dls[0];
    end
    r.active_count = sched_used[5:0];
    r.overdue_count = sched_overdue;
    r.last_overdue_id = sched_last_id;
    return r;
  endfunction

  function automatic item_t make_event(logic [1:0] act, logic [15:0] id,
                                       logic [23:0] rel, logic [31:0] now);
    item_t it;
    it.action = act;
    it.task_id = id;
    it.relative_deadline = rel;
    it.now_ms = now;
    return it;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Driver: present the next transaction, hold until accepted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      item_i <= '0;
      gap_left <= 0;
    end else if (start && !busy) begin
      expected_results.push_back(schedule_event(item_i));
      if (pending_items.size() > 0 && gap_left == 0 && $urandom_range(0, 1)) begin
        item_i <= pending_items.pop_front();
      end else begin
        start <= 1'b0;
        gap_left <= pick_gap();
      end
    end else if (!start) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (pending_items.size() > 0) begin
        item_i <= pending_items.pop_front();
        start <= 1'b1;
      end
    end
  end

  // Monitor: compare each strobed result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, result_o);
        errors++;
      end else if (expected_results[0] !== result_o) begin
        $display("%0t: mismatch expected %h actual %h", $time,
                 expected_results[0], result_o);
        errors++;
        void'(expected_results.pop_front());
      end else begin
        void'(expected_results.pop_front());
      end
    end
  end

  // Stimulus
  initial begin
    logic [15:0] ids[$];
    logic [15:0] id;
    int p;
    // Directed: empty removals, saturation, equal deadlines, extremes
    pending_items.push_back(make_event(ACT_COMPLETE, 16'h0001, '0, '0));
    pending_items.push_back(make_event(ACT_EXPIRE, 16'hFFFF, '0, '0));
    pending_items.push_back(make_event(ACT_CREATE, 16'h0000, '0, '0));
    pending_items.push_back(make_event(ACT_CREATE, 16'hFFFF, 24'hFFFFFF, 32'hFFFFFFFF));
    pending_items.push_back(make_event(ACT_CREATE, 16'h0005, 24'd10, 32'd100));
    pending_items.push_back(make_event(ACT_CREATE, 16'h0006, 24'd0, 32'd110));
    pending_items.push_back(make_event(ACT_CREATE, 16'h0005, 24'd5, 32'd105));
    pending_items.push_back(make_event(ACT_EXPIRE, 16'h0005, '0, '0));
    pending_items.push_back(make_event(ACT_COMPLETE, 16'hFFFF, '0, '0));
    pending_items.push_back(make_event(ACT_EXPIRE, 16'h1234, '0, '0));
    pending_items.push_back(make_event(ACT_COMPLETE, 16'h0000, '0, '0));
    pending_items.push_back(make_event(ACT_FLUSH, 16'hAAAA, 24'h555555, 32'hAAAAAAAA));
    // Fill past capacity, then drain the tail entry
    for (int i = 0; i < MAX_TASKS + 2; i++)
      pending_items.push_back(make_event(ACT_CREATE, 16'(i), 24'(i * 7), 32'd1000));
    pending_items.push_back(make_event(ACT_COMPLETE, 16'(MAX_TASKS - 1), '0, '0));
    pending_items.push_back(make_event(ACT_FLUSH, '0, '0, '0));
    // Random: mostly create then remove known ids, some noise
    for (int n = 0; n < 1150; n++) begin
      p = $urandom_range(0, 99);
      if (p < 45 || ids.size() == 0) begin
        id = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 7)) : 16'($urandom);
        ids.push_back(id);
        pending_items.push_back(make_event(ACT_CREATE, id,
          ($urandom_range(0, 3) == 0) ? 24'($urandom_range(0, 3)) : 24'($urandom),
          ($urandom_range(0, 7) == 0) ? 32'hFFFFFFFF - $urandom_range(0, 9) : $urandom));
        if (ids.size() > 40) void'(ids.pop_front());
      end else if (p < 90) begin
        id = ids[$urandom_range(0, ids.size() - 1)];
        pending_items.push_back(make_event(($urandom_range(0, 1)) ? ACT_EXPIRE : ACT_COMPLETE,
                                           id, 24'($urandom), $urandom));
      end else if (p < 98) begin
        pending_items.push_back(make_event(($urandom_range(0, 1)) ? ACT_EXPIRE : ACT_COMPLETE,
                                           16'($urandom), 24'($urandom), $urandom));
      end else begin
        pending_items.push_back(make_event(ACT_FLUSH, 16'($urandom), 24'($urandom), $urandom));
        ids.delete();
      end
    end
    wait (pending_items.size() == 0 && !start);
    wait (expected_results.size() == 0);
    repeat (100) @(posedge clk_i);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end
endmodule
